// ----- rtl/core/kest_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kest_pkg: key edge state table shared definitions
// Field widths, operation and key state codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package kest_pkg;

   localparam int OP_W           = 3;
   localparam int KEY_W          = 25;
   localparam int STATE_W        = 2;
   localparam int LIST_DEPTH_DEF = 16;

   typedef enum logic [OP_W-1:0] {
      OP_PRESS   = 3'd0,
      OP_RELEASE = 3'd1,
      OP_TICK    = 3'd2,
      OP_QUERY   = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   typedef enum logic [STATE_W-1:0] {
      KS_INVALID = 2'd0,
      KS_TRIG    = 2'd1,
      KS_PRESS   = 2'd2,
      KS_REL     = 2'd3
   } key_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_RESP
   } ctrl_state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [STATE_W-1:0] state;
   } entry_type;

   // Controller to datapath
   typedef struct packed {
      logic req_take;     // latch the request payload
      logic do_press;     // append an entry or flag the drop
      logic do_clear;     // empty the list
      logic ptr_clear;    // restart read and write pointers
      logic ptr_read;     // read the entry at the read pointer
      logic scan_check;   // act on a search hit or advance
      logic tick_check;   // keep or drop the entry just read
      logic tick_finish;  // commit the compacted count
      logic rsp_load;     // load the response register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            at_end;
      logic            key_match;
      logic            rsp_free;
   } status_type;

endpackage : kest_pkg
`default_nettype wire

// ----- rtl/core/kest_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kest_req_if: key event request channel
// Valid/ready channel carrying one key event.
// ----------------------------------------------------------------------------
interface kest_req_if import kest_pkg::*; ();

   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  operation;
   logic [KEY_W-1:0] key_code;

   modport source (output valid, output operation, output key_code, input ready);
   modport sink   (input valid, input operation, input key_code, output ready);

endinterface : kest_req_if
`default_nettype wire

// ----- rtl/core/kest_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kest_rsp_if: key event response channel
// Valid/ready channel carrying the answer to one key event.
// ----------------------------------------------------------------------------
interface kest_rsp_if import kest_pkg::*; ();

   logic               valid;
   logic               ready;
   logic [STATE_W-1:0] key_state;
   logic               dropped;

   modport source (output valid, output key_state, output dropped, input ready);
   modport sink   (input valid, input key_state, input dropped, output ready);

endinterface : kest_rsp_if
`default_nettype wire

// ----- rtl/core/kest_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kest_ctrl: key edge state table controller
// Sequences press, clear, search, compaction and response steps of one request.
// ----------------------------------------------------------------------------
module kest_ctrl import kest_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.op) inside
               OP_RELEASE, OP_QUERY: state_in = ST_SCAN_RD;
               OP_TICK:              state_in = ST_TICK_RD;
               default:              state_in = ST_RESP;
            endcase
         end
         ST_SCAN_RD: begin
            state_in = status.at_end ? ST_RESP : ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            state_in = status.key_match ? ST_RESP : ST_SCAN_RD;
         end
         ST_TICK_RD: begin
            state_in = status.at_end ? ST_RESP : ST_TICK_CHK;
         end
         ST_TICK_CHK: begin
            state_in = ST_TICK_RD;
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.req_take = req_valid;
         end
         ST_DECODE: begin
            unique case (status.op) inside
               OP_PRESS:                      cmd.do_press  = 1'b1;
               OP_CLEAR:                      cmd.do_clear  = 1'b1;
               OP_RELEASE, OP_QUERY, OP_TICK: cmd.ptr_clear = 1'b1;
               default:                       cmd = '0;
            endcase
         end
         ST_SCAN_RD: begin
            cmd.ptr_read = !status.at_end;
         end
         ST_SCAN_CHK: begin
            cmd.scan_check = 1'b1;
         end
         ST_TICK_RD: begin
            cmd.ptr_read    = !status.at_end;
            cmd.tick_finish = status.at_end;
         end
         ST_TICK_CHK: begin
            cmd.tick_check = 1'b1;
         end
         ST_RESP: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: cmd = '0;
      endcase
   end

`ifndef SYNTHESIS
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("response loaded over an unconsumed response");

   a_take_to_decode: assert property (@(posedge clock) disable iff (reset)
      cmd.req_take |=> state_ff == ST_DECODE)
      else $error("accepted request not decoded");
`endif

endmodule : kest_ctrl
`default_nettype wire

// ----- rtl/core/kest_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kest_dp: key edge state table datapath
// Entry memory, fill count, scan pointers, result and response registers.
// ----------------------------------------------------------------------------
module kest_dp import kest_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic [OP_W-1:0]    req_operation,
   input  wire logic [KEY_W-1:0]   req_key_code,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [STATE_W-1:0]      rsp_key_state,
   output logic                    rsp_dropped,
   output status_type              status
);

   localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(LIST_DEPTH);

   entry_type mem [LIST_DEPTH];
   entry_type rd_data_ff;

   logic [OP_W-1:0]    op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   wr_ff, wr_in;
   logic [STATE_W-1:0] ans_ff, ans_in;
   logic               drop_ff, drop_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0] rsp_state_ff;
   logic               rsp_drop_ff;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   entry_type         mem_wdata;
   logic              key_match;
   logic              rd_released;

   assign key_match   = (rd_data_ff.key == key_ff);
   assign rd_released = (rd_data_ff.state == KS_REL);

   // Memory write port and next values
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = count_ff[ADDR_W-1:0];
      mem_wdata = '{key: key_ff, state: KS_TRIG};
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      wr_in     = wr_ff;
      ans_in    = ans_ff;
      drop_in   = drop_ff;

      if (cmd.req_take) begin
         ans_in  = KS_INVALID;
         drop_in = 1'b0;
      end
      if (cmd.do_press) begin
         if (count_ff == FULL) begin
            drop_in = 1'b1;
         end else begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.do_clear) begin
         count_in = '0;
      end
      if (cmd.ptr_clear) begin
         ptr_in = '0;
         wr_in  = '0;
      end
      if (cmd.scan_check) begin
         if (key_match) begin
            if (op_ff == OP_RELEASE) begin
               mem_we    = 1'b1;
               mem_waddr = ptr_ff[ADDR_W-1:0];
               mem_wdata = '{key: rd_data_ff.key, state: KS_REL};
            end else begin
               ans_in = rd_data_ff.state;
            end
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
      if (cmd.tick_check) begin
         ptr_in = ptr_ff + 1'b1;
         if (!rd_released) begin
            mem_we          = 1'b1;
            mem_waddr       = wr_ff[ADDR_W-1:0];
            mem_wdata.key   = rd_data_ff.key;
            mem_wdata.state = (rd_data_ff.state == KS_TRIG) ? KS_PRESS : rd_data_ff.state;
            wr_in           = wr_ff + 1'b1;
         end
      end
      if (cmd.tick_finish) begin
         count_in = wr_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.ptr_read) begin
         rd_data_ff <= mem[ptr_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.req_take) begin
         op_ff  <= req_operation;
         key_ff <= req_key_code;
      end
      if (cmd.rsp_load) begin
         rsp_state_ff <= ans_ff;
         rsp_drop_ff  <= drop_ff;
      end
      ptr_ff  <= ptr_in;
      wr_ff   <= wr_in;
      ans_ff  <= ans_in;
      drop_ff <= drop_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_state = rsp_state_ff;
   assign rsp_dropped   = rsp_drop_ff;

   assign status.op        = op_ff;
   assign status.at_end    = (ptr_ff == count_ff);
   assign status.key_match = key_match;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL)
      else $error("entry count beyond list depth");

   a_full_press_drops: assert property (@(posedge clock) disable iff (reset)
      cmd.do_press && count_ff == FULL |=> drop_ff && $stable(count_ff))
      else $error("press on a full list not dropped");
`endif

endmodule : kest_dp
`default_nettype wire

// ----- rtl/core/key_edge_state_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// key_edge_state_table: ordered table of held keys with edge states
// Tracks pressed keys as triggered, pressed or released entries, compacts
// released entries on a frame tick and answers state queries.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake     | payload
//   ---------+-----------+---------------+------------------------------
//   req_if   | in        | valid / ready | operation[2:0], key_code[24:0]
//   rsp_if   | out       | valid / ready | key_state[1:0], dropped
//
// Sequence: one request at a time. Press, clear and unused codes pass
//   through accept, decode and response. Release and query read and check
//   one entry after another from the oldest until the first hit or the end
//   of the list. A frame tick reads and checks every entry in order. The
//   entry memory has a registered read, so each entry is read, then checked.
// Reset: synchronous; empties the list and drops any pending response.
// Stalls: the response waits in an output register; the next request is
//   taken while it waits, and a second response holds until rsp_if.ready.
// ----------------------------------------------------------------------------
module key_edge_state_table import kest_pkg::*; #(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   kest_req_if.sink   req_if,
   kest_rsp_if.source rsp_if
);

   cmd_type    cmd;
   status_type status;

   // Controller: walks each request through decode, scan and response
   kest_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: entry memory, count, pointers and response register
   kest_dp #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_operation (req_if.operation),
      .req_key_code  (req_if.key_code),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .rsp_key_state (rsp_if.key_state),
      .rsp_dropped   (rsp_if.dropped),
      .status        (status)
   );

endmodule : key_edge_state_table
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the key edge state table
// Drives key events through the request channel, predicts each answer with a
// shadow copy of the held-key list and compares every response field by
// field. A short table of directed events runs first, then random sessions,
// list-filling bursts and noise, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top import kest_pkg::*; ();

   localparam int LIST_DEPTH     = LIST_DEPTH_DEF;
   localparam int TOTAL_EVENTS   = 1900;
   localparam int QUIET_EVENTS   = 200;   // no idling over the last stretch
   localparam int LATENCY_TAIL   = 80;    // a full frame tick plus stalls
   localparam int DIRECTED_ROWS  = 25;
   localparam int POOL_MAX       = 8;

   // Operation codes the block has no meaning for
   localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
   localparam logic [OP_W-1:0] OP_RSVD_MID   = 3'd6;
   localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

   localparam logic [KEY_W-1:0] KEY_MIN  = '0;
   localparam logic [KEY_W-1:0] KEY_MAX  = '1;
   localparam logic [KEY_W-1:0] KEY_ODD  = 25'h1555555;
   localparam logic [KEY_W-1:0] KEY_EVEN = 25'h0AAAAAA;

   typedef struct packed {
      key_state_type key_state;
      logic          dropped;
   } key_answer_type;

   localparam key_answer_type ANS_NONE  = '{KS_INVALID, 1'b0};
   localparam key_answer_type ANS_TRIG  = '{KS_TRIG, 1'b0};
   localparam key_answer_type ANS_PRESS = '{KS_PRESS, 1'b0};
   localparam key_answer_type ANS_REL   = '{KS_REL, 1'b0};

   // One directed key event; the answer is typed in only where it is obvious
   typedef struct {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      bit               typed;
      key_answer_type   answer;
   } event_row_type;

   logic clock;
   logic reset;

   kest_req_if req_if ();
   kest_rsp_if rsp_if ();

   key_edge_state_table #(
      .LIST_DEPTH (LIST_DEPTH)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Shadow copy of the held-key list
   logic [KEY_W-1:0] shadow_key   [LIST_DEPTH];
   key_state_type    shadow_state [LIST_DEPTH];
   int unsigned      shadow_count;

   key_answer_type   pending_answers [$];
   key_answer_type   oldest_answer;
   int unsigned      mismatch_count;
   int unsigned      events_sent;
   bit               idle_enable;
   int unsigned      ready_hold;

   logic [KEY_W-1:0] key_pool [POOL_MAX];
   int unsigned      pool_size;

   // Directed events: extremes, each operation, duplicates, repeated release,
   // absent keys and the unused operation codes
   event_row_type directed_plan [DIRECTED_ROWS] = '{
      '{OP_QUERY,      KEY_MIN,  1'b1, ANS_NONE},   // empty list after reset
      '{OP_RELEASE,    KEY_MIN,  1'b1, ANS_NONE},   // release of an absent key
      '{OP_PRESS,      KEY_MIN,  1'b1, ANS_NONE},
      '{OP_PRESS,      KEY_MAX,  1'b1, ANS_NONE},
      '{OP_QUERY,      KEY_MIN,  1'b1, ANS_TRIG},
      '{OP_RELEASE,    KEY_MAX,  1'b1, ANS_NONE},
      '{OP_QUERY,      KEY_MAX,  1'b1, ANS_REL},
      '{OP_TICK,       KEY_ODD,  1'b1, ANS_NONE},
      '{OP_QUERY,      KEY_MAX,  1'b1, ANS_NONE},   // released entry removed
      '{OP_QUERY,      KEY_MIN,  1'b1, ANS_PRESS},  // triggered entry promoted
      '{OP_PRESS,      KEY_MIN,  1'b0, ANS_NONE},   // duplicate press
      '{OP_RELEASE,    KEY_MIN,  1'b0, ANS_NONE},   // hits the older entry
      '{OP_QUERY,      KEY_MIN,  1'b0, ANS_NONE},
      '{OP_RELEASE,    KEY_MIN,  1'b0, ANS_NONE},   // already released stays
      '{OP_QUERY,      KEY_MIN,  1'b0, ANS_NONE},
      '{OP_TICK,       KEY_MIN,  1'b0, ANS_NONE},
      '{OP_QUERY,      KEY_MIN,  1'b0, ANS_NONE},   // younger duplicate left
      '{OP_PRESS,      KEY_ODD,  1'b0, ANS_NONE},
      '{OP_QUERY,      KEY_EVEN, 1'b0, ANS_NONE},   // query of an absent key
      '{OP_RSVD_FIRST, KEY_MAX,  1'b1, ANS_NONE},
      '{OP_RSVD_MID,   KEY_ODD,  1'b1, ANS_NONE},
      '{OP_RSVD_LAST,  KEY_EVEN, 1'b1, ANS_NONE},
      '{OP_QUERY,      KEY_ODD,  1'b0, ANS_NONE},   // unused codes left it alone
      '{OP_CLEAR,      KEY_MAX,  1'b1, ANS_NONE},
      '{OP_QUERY,      KEY_MIN,  1'b1, ANS_NONE}    // empty after clear
   };

   // Clock and reset
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Time limit far beyond the slowest correct run
   initial begin
      #8_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Apply one key event to the shadow list and return the answer it yields
   function automatic key_answer_type apply_key_event(input logic [OP_W-1:0]  op,
                                                      input logic [KEY_W-1:0] key);
      key_answer_type answer;
      int             hit;
      int             i;
      int             w;
      answer = ANS_NONE;
      hit    = -1;
      // Find the oldest matching entry; scan backward so the lowest wins
      for (i = int'(shadow_count) - 1; i >= 0; i--) begin
         if (shadow_key[i] == key) hit = i;
      end
      case (op)
         OP_PRESS: begin
            if (shadow_count >= LIST_DEPTH) begin
               answer.dropped = 1'b1;
            end else begin
               shadow_key[shadow_count]   = key;
               shadow_state[shadow_count] = KS_TRIG;
               shadow_count++;
            end
         end
         OP_RELEASE: begin
            if (hit >= 0) shadow_state[hit] = KS_REL;
         end
         OP_TICK: begin
            // Drop released entries, promote triggered ones, keep the order
            w = 0;
            for (i = 0; i < int'(shadow_count); i++) begin
               if (shadow_state[i] != KS_REL) begin
                  shadow_key[w] = shadow_key[i];
                  if (shadow_state[i] == KS_TRIG) begin
                     shadow_state[w] = KS_PRESS;
                  end else begin
                     shadow_state[w] = shadow_state[i];
                  end
                  w++;
               end
            end
            shadow_count = w;
         end
         OP_QUERY: begin
            if (hit >= 0) answer.key_state = shadow_state[hit];
         end
         OP_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      return answer;
   endfunction

   // Present one request, hold it until accepted, then record its answer.
   // The caller sits on the accepting edge when this returns.
   task automatic send_key_event(input logic [OP_W-1:0]  op,
                                 input logic [KEY_W-1:0] key,
                                 input bit               typed,
                                 input key_answer_type   typed_answer);
      key_answer_type predicted;
      key_answer_type recorded;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.key_code  <= key;
      do @(posedge clock); while (!req_if.ready);
      predicted       = apply_key_event(op, key);
      recorded        = typed ? typed_answer : predicted;
      pending_answers = {pending_answers, recorded};
      if (op <= OP_CLEAR) events_sent++;
   endtask

   // Hold off the request side until every answer is back
   task automatic wait_for_answers();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
   endtask

   // Draw a fresh pool of keys so presses, releases and queries collide
   task automatic refill_key_pool();
      int unsigned i;
      pool_size = $urandom_range(2, POOL_MAX);
      for (i = 0; i < pool_size; i++) begin
         case ($urandom_range(0, 9))
            0:       key_pool[i] = KEY_MIN;
            1:       key_pool[i] = KEY_MAX;
            default: key_pool[i] = KEY_W'($urandom());
         endcase
      end
   endtask

   function automatic logic [KEY_W-1:0] pool_key();
      return key_pool[$urandom_range(0, pool_size - 1)];
   endfunction

   function automatic logic [OP_W-1:0] unused_op();
      case ($urandom_range(0, 2))
         0:       return OP_RSVD_FIRST;
         1:       return OP_RSVD_MID;
         default: return OP_RSVD_LAST;
      endcase
   endfunction

   // Response side: hold ready low in random bursts
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold   <= ready_hold - 1;
         rsp_if.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         ready_hold   <= $urandom_range(0, 3);
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Check every accepted response against the oldest outstanding answer
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response: expected none, actual state %0d dropped %0b",
                     $time, rsp_if.key_state, rsp_if.dropped);
         end else begin
            oldest_answer = pending_answers.pop_front();
            if (rsp_if.key_state !== oldest_answer.key_state) begin
               mismatch_count++;
               $display("%0t: key_state mismatch: expected %0d, actual %0d",
                        $time, oldest_answer.key_state, rsp_if.key_state);
            end
            if (rsp_if.dropped !== oldest_answer.dropped) begin
               mismatch_count++;
               $display("%0t: dropped mismatch: expected %0b, actual %0b",
                        $time, oldest_answer.dropped, rsp_if.dropped);
            end
         end
      end
   end

   // Stimulus
   initial begin
      int               row;
      int               n;
      int               roll;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;

      // Drive every input to a known value before the first edge
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.operation = OP_PRESS;
      req_if.key_code  = '0;
      rsp_if.ready     = 1'b0;
      ready_hold       = 0;
      idle_enable      = 1'b1;
      shadow_count     = 0;
      mismatch_count   = 0;
      events_sent      = 0;
      foreach (shadow_state[i]) shadow_state[i] = KS_INVALID;
      foreach (shadow_key[i]) shadow_key[i] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         send_key_event(directed_plan[row].op, directed_plan[row].key,
                        directed_plan[row].typed, directed_plan[row].answer);
      end
      // Pause until the table has fully answered
      wait_for_answers();

      // Random part: mostly sessions over a small key pool
      while (events_sent < TOTAL_EVENTS) begin
         // Turn idling off for the final stretch, else leave some quiet runs
         if (events_sent >= TOTAL_EVENTS - QUIET_EVENTS) begin
            idle_enable = 1'b0;
         end else begin
            idle_enable = ($urandom_range(0, 4) != 0);
         end
         roll = $urandom_range(0, 19);
         if (roll < 11) begin
            // Session: mixed events on colliding keys
            refill_key_pool();
            n = $urandom_range(8, 40);
            repeat (n) begin
               roll = $urandom_range(0, 99);
               key  = pool_key();
               if (roll < 35) begin
                  op = OP_PRESS;
               end else if (roll < 55) begin
                  op = OP_RELEASE;
               end else if (roll < 80) begin
                  op = OP_QUERY;
               end else if (roll < 92) begin
                  op = OP_TICK;
               end else if (roll < 94) begin
                  op = OP_CLEAR;
               end else if (roll < 97) begin
                  op = unused_op();
               end else begin
                  // Probe with a key that is most likely absent
                  op  = ($urandom_range(0, 1) != 0) ? OP_QUERY : OP_RELEASE;
                  key = KEY_W'($urandom());
               end
               send_key_event(op, key, 1'b0, ANS_NONE);
            end
         end else if (roll < 15) begin
            // Fill burst: press the list near or past full; extra presses drop
            refill_key_pool();
            n = $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 4);
            repeat (n) send_key_event(OP_PRESS, pool_key(), 1'b0, ANS_NONE);
            repeat (3) send_key_event(OP_QUERY, pool_key(), 1'b0, ANS_NONE);
            repeat ($urandom_range(0, 3))
               send_key_event(OP_RELEASE, pool_key(), 1'b0, ANS_NONE);
            send_key_event(OP_TICK, KEY_W'($urandom()), 1'b0, ANS_NONE);
            repeat (2) send_key_event(OP_QUERY, pool_key(), 1'b0, ANS_NONE);
         end else if (roll < 18) begin
            // Noise: any code, any key
            n = $urandom_range(5, 15);
            repeat (n) begin
               send_key_event(OP_W'($urandom_range(0, 7)), KEY_W'($urandom()),
                              1'b0, ANS_NONE);
            end
         end else begin
            // Drain fully, then start over from an empty list
            wait_for_answers();
            send_key_event(OP_CLEAR, KEY_W'($urandom()), 1'b0, ANS_NONE);
         end
      end

      // Drop valid and let every answer come home, then allow a quiet tail
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_answers.size() != 0);
      repeat (LATENCY_TAIL) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule : tb_top

// ----- sim.f -----
rtl/core/kest_pkg.sv
rtl/core/kest_req_if.sv
rtl/core/kest_rsp_if.sv
rtl/core/kest_ctrl.sv
rtl/core/kest_dp.sv
rtl/core/key_edge_state_table.sv
test/tb_top.sv
